FILE: hdl/olc_pkg.sv
`default_nettype none

package olc_pkg;

    localparam int SIGNAL_DEPTH = 32;
    localparam int KERNEL_DEPTH = 32;
    localparam int LEN_LIMIT    = 32;

    localparam int SIGNAL_AW = $clog2(SIGNAL_DEPTH);
    localparam int KERNEL_AW = $clog2(KERNEL_DEPTH);

    localparam int SIGNAL_LEN_MAX = (SIGNAL_DEPTH < LEN_LIMIT) ? SIGNAL_DEPTH : LEN_LIMIT;
    localparam int KERNEL_LEN_MAX = (KERNEL_DEPTH < LEN_LIMIT) ? KERNEL_DEPTH : LEN_LIMIT;

    localparam int LEN_W   = 6;
    localparam int J_W     = $clog2(LEN_LIMIT);
    localparam int START_W = 11;
    localparam int FIRST_W = START_W + 1;
    localparam int CFG_W   = 11;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 13;
    localparam int OUT_W   = 48;
    localparam int ACC_W   = 64;
    localparam int FRAC_W  = 16;

    typedef enum logic [1:0] {
        CMD_LOAD_SIGNAL = 2'd0,
        CMD_LOAD_KERNEL = 2'd1,
        CMD_RUN         = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_SIGNAL_START  = 2'd0,
        REG_SIGNAL_LENGTH = 2'd1,
        REG_KERNEL_START  = 2'd2,
        REG_KERNEL_LENGTH = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [4:0]                 element_index;
        logic signed [VALUE_W-1:0]  sample_value;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0]    out_position;
        logic signed [OUT_W-1:0]    out_value;
        logic                       last;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/offset_linear_convolution.sv
// Full linear convolution of a signal and a kernel held in two RAMs. Load
// items (cmd 0 signal, cmd 1 kernel) write one element each. A run item
// (cmd 2) emits one result per position from signal_start+kernel_start
// through the sum of both ends, last set on the final one. Each position is
// summed over kernel_length taps by one shared multiply-accumulate unit fed
// by one read port of each RAM. After a run item is taken, item_stall stays
// high while the issue, multiply and accumulate stages still hold work, and
// it drops as the last result is presented. A stalled result freezes the
// multiply-accumulate pipeline until it is taken, which lengthens the run by
// the stall. A length of zero counts as one and a length above 32 as 32.
// Values are Q16.16; products are shifted to Q16.16, summed in 64 bits and
// saturated to 48 bits signed.
`default_nettype none

module offset_linear_convolution (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [olc_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire olc_pkg::item_t               item,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output olc_pkg::result_t                  result
);

    localparam int LEN_W   = olc_pkg::LEN_W;
    localparam int J_W     = olc_pkg::J_W;
    localparam int FIRST_W = olc_pkg::FIRST_W;
    localparam int POS_W   = olc_pkg::POS_W;
    localparam int ACC_W   = olc_pkg::ACC_W;
    localparam int VALUE_W = olc_pkg::VALUE_W;
    localparam int S_AW    = olc_pkg::SIGNAL_AW;
    localparam int K_AW    = olc_pkg::KERNEL_AW;

    logic [olc_pkg::START_W-1:0] signal_start_reg;
    logic [LEN_W-1:0]            signal_length_reg;
    logic [olc_pkg::START_W-1:0] kernel_start_reg;
    logic [LEN_W-1:0]            kernel_length_reg;

    logic                run_reg;
    logic [LEN_W-1:0]    d_reg;
    logic [J_W-1:0]      j_reg;
    logic [LEN_W-1:0]    sl_reg;
    logic [LEN_W-1:0]    kl_reg;
    logic [FIRST_W-1:0]  first_reg;
    logic [LEN_W-1:0]    last_d_reg;

    logic                s1_valid_reg;
    logic                s1_use_reg;
    logic                s1_jfirst_reg;
    logic                s1_jlast_reg;
    logic                s1_dlast_reg;
    logic [POS_W-1:0]    s1_pos_reg;

    logic                s2_valid_reg;
    logic                s2_jfirst_reg;
    logic                s2_jlast_reg;
    logic                s2_dlast_reg;
    logic [POS_W-1:0]    s2_pos_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    logic                result_valid_reg;
    olc_pkg::result_t    result_reg;

    logic                advance;
    logic                busy;
    logic                item_accept;
    logic                load_signal;
    logic                load_kernel;
    logic                start_run;
    logic [LEN_W-1:0]    sl_eff;
    logic [LEN_W-1:0]    kl_eff;
    logic [LEN_W:0]      si_diff;
    logic                in_range;
    logic                j_last;
    logic                d_last;
    logic                finish;
    logic [VALUE_W-1:0]  sig_rdata;
    logic [VALUE_W-1:0]  ker_rdata;
    logic [S_AW-1:0]     sig_addr;
    logic [K_AW-1:0]     ker_addr;

    function automatic logic [olc_pkg::OUT_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] pos_lim;
        logic signed [ACC_W-1:0] neg_lim;
        pos_lim = (ACC_W'(1) <<< (olc_pkg::OUT_W - 1)) - ACC_W'(1);
        neg_lim = -(ACC_W'(1) <<< (olc_pkg::OUT_W - 1));
        if (v > pos_lim)
        begin
            return pos_lim[olc_pkg::OUT_W-1:0];
        end
        else if (v < neg_lim)
        begin
            return neg_lim[olc_pkg::OUT_W-1:0];
        end
        return v[olc_pkg::OUT_W-1:0];
    endfunction

    assign busy        = run_reg || s1_valid_reg || s2_valid_reg;
    assign item_stall  = busy;
    assign item_accept = item_valid && !busy;
    assign advance     = !(result_valid_reg && result_stall);

    always_comb
    begin
        load_signal = 1'b0;
        load_kernel = 1'b0;
        start_run   = 1'b0;
        unique case (item.cmd)
            olc_pkg::CMD_LOAD_SIGNAL:
            begin
                load_signal = item_accept
                    && (int'(item.element_index) < olc_pkg::SIGNAL_DEPTH);
            end
            olc_pkg::CMD_LOAD_KERNEL:
            begin
                load_kernel = item_accept
                    && (int'(item.element_index) < olc_pkg::KERNEL_DEPTH);
            end
            olc_pkg::CMD_RUN:
            begin
                start_run = item_accept;
            end
            default:
            begin
                start_run = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (signal_length_reg == '0)
        begin
            sl_eff = LEN_W'(1);
        end
        else if (int'(signal_length_reg) > olc_pkg::SIGNAL_LEN_MAX)
        begin
            sl_eff = LEN_W'(olc_pkg::SIGNAL_LEN_MAX);
        end
        else
        begin
            sl_eff = signal_length_reg;
        end
        if (kernel_length_reg == '0)
        begin
            kl_eff = LEN_W'(1);
        end
        else if (int'(kernel_length_reg) > olc_pkg::KERNEL_LEN_MAX)
        begin
            kl_eff = LEN_W'(olc_pkg::KERNEL_LEN_MAX);
        end
        else
        begin
            kl_eff = kernel_length_reg;
        end
    end

    assign si_diff  = {1'b0, d_reg} - (LEN_W + 1)'(j_reg);
    assign in_range = !si_diff[LEN_W] && (si_diff[LEN_W-1:0] < sl_reg);
    assign j_last   = (LEN_W'(j_reg) == (kl_reg - LEN_W'(1)));
    assign d_last   = (d_reg == last_d_reg);

    assign sig_addr = load_signal ? S_AW'(item.element_index) : S_AW'(si_diff);
    assign ker_addr = load_kernel ? K_AW'(item.element_index) : K_AW'(j_reg);

    olc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (olc_pkg::SIGNAL_DEPTH)
    ) u_signal_ram (
        .clk   (clk),
        .we    (load_signal),
        .waddr (sig_addr),
        .wdata (item.sample_value),
        .re    (advance),
        .raddr (sig_addr),
        .rdata (sig_rdata)
    );

    olc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (olc_pkg::KERNEL_DEPTH)
    ) u_kernel_ram (
        .clk   (clk),
        .we    (load_kernel),
        .waddr (ker_addr),
        .wdata (item.sample_value),
        .re    (advance),
        .raddr (ker_addr),
        .rdata (ker_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signal_start_reg  <= '0;
            signal_length_reg <= LEN_W'(1);
            kernel_start_reg  <= '0;
            kernel_length_reg <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                olc_pkg::REG_SIGNAL_START:  signal_start_reg  <= cfg_data;
                olc_pkg::REG_SIGNAL_LENGTH: signal_length_reg <= cfg_data[LEN_W-1:0];
                olc_pkg::REG_KERNEL_START:  kernel_start_reg  <= cfg_data;
                olc_pkg::REG_KERNEL_LENGTH: kernel_length_reg <= cfg_data[LEN_W-1:0];
                default:                    signal_start_reg  <= signal_start_reg;
            endcase
        end
    end

    // issue stage: walk output positions and kernel taps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (start_run)
        begin
            run_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= run_reg;
            if (run_reg && j_last && d_last)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_run)
        begin
            d_reg      <= '0;
            j_reg      <= '0;
            sl_reg     <= sl_eff;
            kl_reg     <= kl_eff;
            first_reg  <= {signal_start_reg[olc_pkg::START_W-1], signal_start_reg}
                        + {kernel_start_reg[olc_pkg::START_W-1], kernel_start_reg};
            last_d_reg <= sl_eff + kl_eff - LEN_W'(2);
        end
        else if (advance && run_reg)
        begin
            s1_use_reg    <= in_range;
            s1_jfirst_reg <= (j_reg == '0);
            s1_jlast_reg  <= j_last;
            s1_dlast_reg  <= d_last;
            s1_pos_reg    <= {first_reg[FIRST_W-1], first_reg}
                           + POS_W'(d_reg);
            if (j_last)
            begin
                j_reg <= '0;
                d_reg <= d_reg + LEN_W'(1);
            end
            else
            begin
                j_reg <= j_reg + J_W'(1);
            end
        end
    end

    // multiply stage; drop taps outside the signal support
    assign prod_next = s1_use_reg
        ? ($signed({{(ACC_W-VALUE_W){ker_rdata[VALUE_W-1]}}, ker_rdata})
           * $signed({{(ACC_W-VALUE_W){sig_rdata[VALUE_W-1]}}, sig_rdata}))
        : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            prod_reg      <= prod_next;
            s2_jfirst_reg <= s1_jfirst_reg;
            s2_jlast_reg  <= s1_jlast_reg;
            s2_dlast_reg  <= s1_dlast_reg;
            s2_pos_reg    <= s1_pos_reg;
        end
    end

    // accumulate stage
    assign acc_next = (s2_jfirst_reg ? ACC_W'(0) : acc_reg) + (prod_reg >>> olc_pkg::FRAC_W);
    assign finish   = advance && s2_valid_reg && s2_jlast_reg;

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (finish)
        begin
            result_reg.out_position <= s2_pos_reg;
            result_reg.out_value    <= sat48(acc_next);
            result_reg.last         <= s2_dlast_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= finish;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> item_stall)
        else $error("item accepted during a run");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (d_reg <= last_d_reg) && (LEN_W'(j_reg) < kl_reg))
        else $error("walk beyond output range");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> result_valid)
        else $error("finished sum not presented");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall && s2_valid_reg) |=> s2_valid_reg && $stable(prod_reg))
        else $error("pipeline moved under output stall");

endmodule

`default_nettype wire

FILE: hdl/olc_ram.sv
`default_nettype none

module olc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
